FILE: rtl/kmse_pkg.sv
package kmse_pkg;

    localparam int HOST_KEYS   = 72;
    localparam int TARGET_KEYS = 64;

    localparam logic [5:0] CAPS_CODE  = 6'h35;
    localparam logic [5:0] SHIFT_CODE = 6'h3F;
    localparam logic [5:0] ESC_CODE   = 6'h30;
    localparam logic [5:0] M_CODE     = 6'h0D;
    localparam logic [6:0] HK_LSHIFT  = 7'd54;
    localparam logic [6:0] HK_RSHIFT  = 7'd55;
    localparam logic [6:0] HK_LCTRL   = 7'd47;
    localparam logic [6:0] HK_RCTRL   = 7'd48;

    // operation codes
    localparam logic [2:0] OP_KEYDOWN   = 3'd0;
    localparam logic [2:0] OP_KEYUP     = 3'd1;
    localparam logic [2:0] OP_SCAN_ONE  = 3'd2;
    localparam logic [2:0] OP_SCAN_ALL  = 3'd3;
    localparam logic [2:0] OP_FORCE     = 3'd4;
    localparam logic [2:0] OP_FORCE_NON = 3'd5;
    localparam logic [2:0] OP_SET       = 3'd6;
    localparam logic [2:0] OP_CLEAR     = 3'd7;

    // configuration register indexes
    localparam logic [2:0] REG_CTRL_SHIFT_RAW = 3'd0;
    localparam logic [2:0] REG_LOCK_FIX       = 3'd1;
    localparam logic [2:0] REG_CAPS_SEMIFIX   = 3'd2;
    localparam logic [2:0] REG_SHIFT_HOLD     = 3'd3;
    localparam logic [2:0] REG_CAPS_REPEAT    = 3'd4;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [6:0]  host_key;
        logic [13:0] pen_address;
        logic [5:0]  target_scan;
        logic [15:0] repeat_count;
        logic        rom_latched;
    } t_in_item;

    typedef struct packed {
        logic        pen_strobe;
        logic [13:0] pen_strobe_address;
        logic        escape_down;
        logic        m_down;
    } t_out_item;

    // controller -> datapath commands
    typedef struct packed {
        logic       load;     // capture input item
        logic       exec;     // run non-scan op
        logic       probe;    // probe one scan code
        logic [5:0] scan;     // code to probe
        logic       finish;   // latch result
        logic       hit;      // strobe result
        logic       use_idx;  // address from scan index
    } t_cmd;

    // bit 7 mapped, bits 5:0 code
    function automatic logic [7:0] lower_map(input logic [6:0] k);
        logic [7:0] r;
        r = 8'h00;
        if (k <= 7'd28) r = 8'h81 + {1'b0, k};
        else unique case (k)
            7'd29: r = 8'h9F; 7'd30: r = 8'h00; 7'd31: r = 8'hA1;
            7'd32: r = 8'hA3; 7'd33: r = 8'hA4; 7'd34: r = 8'hA5;
            7'd35: r = 8'hAC; 7'd36: r = 8'hAE; 7'd37: r = 8'hAF;
            7'd38: r = 8'hB0; 7'd39: r = 8'hB1; 7'd40: r = 8'hB2;
            7'd41: r = 8'hB3; 7'd42: r = 8'hB4; 7'd43: r = 8'hB5;
            7'd44: r = 8'hB6; 7'd45: r = 8'hB7; 7'd46: r = 8'hB8;
            7'd47: r = 8'hB9; 7'd48: r = 8'hB9; 7'd49: r = 8'hBA;
            7'd50: r = 8'hBB; 7'd51: r = 8'hBC; 7'd52: r = 8'hBD;
            7'd53: r = 8'hBE; 7'd54: r = 8'hBF; 7'd55: r = 8'hBF;
            7'd56: r = 8'hA0; 7'd57: r = 8'hA2; 7'd58: r = 8'hA6;
            7'd59: r = 8'hA7; 7'd60: r = 8'hA8; 7'd61: r = 8'hA9;
            7'd62: r = 8'h80; 7'd63: r = 8'hA7; 7'd64: r = 8'hAB;
            7'd65: r = 8'hAD; 7'd66: r = 8'hAD;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] shift_map(input logic [6:0] k);
        logic [7:0] r;
        unique case (k)
            7'd30: r = 8'hA0;
            7'd56: r = 8'hA9; 7'd57: r = 8'h80; 7'd58: r = 8'h9E;
            7'd59: r = 8'hA6; 7'd60: r = 8'hAA; 7'd61: r = 8'hA8;
            7'd62: r = 8'h9E; 7'd63: r = 8'hA2; 7'd64: r = 8'hAA;
            7'd65: r = 8'h9F; 7'd66: r = 8'hAB;
            default: r = lower_map(k);
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/kmse_datapath.sv
module kmse_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  kmse_pkg::t_in_item i_item,
    input  kmse_pkg::t_cmd     i_cmd,
    output logic               o_probe_hit,
    output kmse_pkg::t_in_item o_item,
    output kmse_pkg::t_out_item o_result
);

    // configuration
    logic       r_ctrl_shift_raw, r_lock_fix, r_caps_semifix;
    logic [7:0] r_shift_hold;
    logic [3:0] r_caps_repeat;

    // key state
    logic [kmse_pkg::HOST_KEYS-1:0]   r_host_down;
    logic [kmse_pkg::TARGET_KEYS-1:0] r_tdown, r_tinv;
    logic [7:0]  r_stop_shift, r_make_shift;
    logic [5:0]  r_forced_code;
    logic [15:0] r_forced_left, r_none_left;
    logic        r_skip_lock, r_last_caps;
    logic [3:0]  r_caps_left;
    kmse_pkg::t_in_item  r_item;
    kmse_pkg::t_out_item r_result;

    // key event decode
    logic [6:0] hk;
    logic       hk_ok, shift_dn, ctrl_dn, kd_do, kd_inv;
    logic [7:0] kd_e, lo_e, sh_e;
    logic [kmse_pkg::HOST_KEYS-1:0] host_after;
    logic [kmse_pkg::TARGET_KEYS-1:0] ku_clr;

    always_comb begin
        hk = r_item.host_key;
        hk_ok = hk < 7'(kmse_pkg::HOST_KEYS);
        lo_e = kmse_pkg::lower_map(hk);
        sh_e = kmse_pkg::shift_map(hk);
        host_after = r_host_down;
        if (hk_ok) host_after[hk] = 1'b1;
        shift_dn = host_after[kmse_pkg::HK_LSHIFT] | host_after[kmse_pkg::HK_RSHIFT];
        ctrl_dn  = host_after[kmse_pkg::HK_LCTRL] | host_after[kmse_pkg::HK_RCTRL];
        kd_e = lo_e;
        kd_inv = 1'b0;
        if (shift_dn) begin
            if (ctrl_dn && r_ctrl_shift_raw) begin
                kd_e = sh_e[7] ? lo_e : 8'h00;
            end else begin
                kd_e = sh_e;
                kd_inv = (hk == 7'd57) || (hk == 7'd58) || (hk == 7'd64);
            end
        end else begin
            kd_inv = (hk == 7'd62) || (hk == 7'd63) || (hk == 7'd66);
        end
        kd_do = hk_ok && kd_e[7];
        // target codes released by a key up
        ku_clr = '0;
        if (sh_e[7]) ku_clr[sh_e[5:0]] = 1'b1;
        if (lo_e[7]) ku_clr[lo_e[5:0]] = 1'b1;
    end

    // probe of one scan code, mirrors priority of the scan rules
    logic [5:0] sc;
    logic       caps_path, caps_chg;
    logic [3:0] caps_dec;
    always_comb begin
        sc = i_cmd.scan;
        caps_path = !r_lock_fix && r_caps_semifix && sc == kmse_pkg::CAPS_CODE && !r_skip_lock;
        caps_chg = r_tdown[kmse_pkg::CAPS_CODE] != r_last_caps;
        caps_dec = r_caps_left - 4'd1;
        if (caps_path)                      o_probe_hit = caps_chg;
        else if (r_none_left != 16'd0)      o_probe_hit = 1'b0;
        else if (r_forced_left != 16'd0 && r_forced_code == sc) o_probe_hit = 1'b1;
        else if (sc == kmse_pkg::SHIFT_CODE && r_stop_shift != 8'd0) o_probe_hit = 1'b0;
        else if (sc == kmse_pkg::SHIFT_CODE && r_make_shift != 8'd0) o_probe_hit = 1'b1;
        else                                o_probe_hit = r_tdown[sc];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_shift_raw <= 1'b1; r_lock_fix <= 1'b0; r_caps_semifix <= 1'b0;
            r_shift_hold <= 8'd8; r_caps_repeat <= 4'd3;
            r_host_down <= '0; r_tdown <= '0; r_tinv <= '0;
            r_stop_shift <= '0; r_make_shift <= '0; r_forced_code <= '0;
            r_forced_left <= '0; r_none_left <= '0;
            r_skip_lock <= 1'b0; r_last_caps <= 1'b0; r_caps_left <= 4'd3;
            r_result <= '0;
        end else begin
            // configuration writes
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    kmse_pkg::REG_CTRL_SHIFT_RAW: r_ctrl_shift_raw <= i_cfg_data[0];
                    kmse_pkg::REG_LOCK_FIX:       r_lock_fix <= i_cfg_data[0];
                    kmse_pkg::REG_CAPS_SEMIFIX:   r_caps_semifix <= i_cfg_data[0];
                    kmse_pkg::REG_SHIFT_HOLD:     r_shift_hold <= i_cfg_data[7:0];
                    kmse_pkg::REG_CAPS_REPEAT:    r_caps_repeat <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            // non-scan operations
            if (i_cmd.exec) begin
                unique case (r_item.opcode)
                    kmse_pkg::OP_KEYDOWN: begin
                        r_host_down <= host_after;
                        if (kd_do) begin
                            r_tdown[kd_e[5:0]] <= 1'b1;
                            r_tinv[kd_e[5:0]]  <= kd_inv;
                        end
                    end
                    kmse_pkg::OP_KEYUP: begin
                        if (hk_ok) begin
                            r_host_down[hk] <= 1'b0;
                            r_tdown <= r_tdown & ~ku_clr;
                        end
                    end
                    kmse_pkg::OP_FORCE: begin
                        r_forced_code <= r_item.target_scan;
                        r_forced_left <= r_item.repeat_count;
                    end
                    kmse_pkg::OP_FORCE_NON: r_none_left <= r_item.repeat_count;
                    kmse_pkg::OP_SET: begin
                        r_tdown[r_item.target_scan] <= 1'b1;
                        r_tinv[r_item.target_scan]  <= 1'b0;
                        if (r_item.target_scan == kmse_pkg::CAPS_CODE) r_skip_lock <= 1'b1;
                    end
                    kmse_pkg::OP_CLEAR: begin
                        r_tdown[r_item.target_scan] <= 1'b0;
                        if (r_item.target_scan == kmse_pkg::CAPS_CODE) r_skip_lock <= 1'b0;
                    end
                    default: ;
                endcase
            end
            // probe side effects
            if (i_cmd.probe) begin
                if (caps_path) begin
                    if (caps_chg) begin
                        r_caps_left <= (caps_dec == 4'd0) ? r_caps_repeat : caps_dec;
                        if (caps_dec == 4'd0) r_last_caps <= r_tdown[kmse_pkg::CAPS_CODE];
                    end
                end else if (r_none_left != 16'd0) begin
                    r_none_left <= r_none_left - 16'd1;
                end else if (r_forced_left != 16'd0 && r_forced_code == sc) begin
                    r_forced_left <= r_forced_left - 16'd1;
                end else if (sc == kmse_pkg::SHIFT_CODE && r_stop_shift != 8'd0) begin
                    r_stop_shift <= r_stop_shift - 8'd1;
                end else if (sc == kmse_pkg::SHIFT_CODE && r_make_shift != 8'd0) begin
                    r_make_shift <= r_make_shift - 8'd1;
                end else if (r_tdown[sc] && r_tinv[sc]) begin
                    if (r_tdown[kmse_pkg::SHIFT_CODE]) r_stop_shift <= r_shift_hold;
                    else r_make_shift <= r_shift_hold;
                end
            end
            // result latch
            if (i_cmd.finish) begin
                r_result.pen_strobe <= i_cmd.hit;
                r_result.pen_strobe_address <= !i_cmd.hit ? 14'd0 :
                    i_cmd.use_idx ? {4'd0, i_cmd.scan, 4'd0} : r_item.pen_address;
                r_result.escape_down <= r_tdown[kmse_pkg::ESC_CODE];
                r_result.m_down <= r_tdown[kmse_pkg::M_CODE];
            end
        end
    end

    // payload capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_item <= i_item;
    end

    assign o_item   = r_item;
    assign o_result = r_result;

endmodule

FILE: rtl/kmse_ctrl.sv
module kmse_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  kmse_pkg::t_in_item i_item,
    input  logic               i_probe_hit,
    output kmse_pkg::t_cmd     o_cmd
);

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SCAN, S_DONE} t_state;

    t_state     r_state;
    logic [5:0] r_idx;
    logic       r_out_valid;

    // output slot frees when taken, so a new item can be accepted alongside
    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd = '0;
        o_cmd.load = i_in_valid && o_in_ready;
        o_cmd.scan = (i_item.opcode == kmse_pkg::OP_SCAN_ONE) ?
                     i_item.pen_address[9:4] : r_idx;
        unique case (r_state)
            S_EXEC: begin
                unique case (i_item.opcode)
                    kmse_pkg::OP_SCAN_ONE: begin
                        o_cmd.probe = 1'b1; o_cmd.finish = 1'b1; o_cmd.hit = i_probe_hit;
                    end
                    kmse_pkg::OP_SCAN_ALL: begin
                        o_cmd.finish = i_item.rom_latched;
                    end
                    default: begin
                        o_cmd.exec = 1'b1;
                    end
                endcase
            end
            S_SCAN: begin
                o_cmd.probe = 1'b1;
                o_cmd.use_idx = 1'b1;
                o_cmd.hit = i_probe_hit;
                o_cmd.finish = i_probe_hit || (r_idx == 6'd63);
            end
            S_DONE: o_cmd.finish = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.finish) r_out_valid <= 1'b1;
            else if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (o_cmd.load) r_state <= S_EXEC;
                S_EXEC: begin
                    r_idx <= '0;
                    if (o_cmd.finish) r_state <= S_IDLE;
                    else if (i_item.opcode == kmse_pkg::OP_SCAN_ALL) r_state <= S_SCAN;
                    else r_state <= S_DONE;
                end
                S_SCAN: begin
                    r_idx <= r_idx + 6'd1;
                    if (o_cmd.finish) r_state <= S_IDLE;
                end
                S_DONE: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/keyboard_matrix_scan_emulator.sv
// Keyboard matrix scan emulator. Each item takes one op; one result item
// per input item. Key events, force, force none, set and clear run in the
// exec state and latch the result in the done state; scan one and scan all
// with the rom latched latch it in the exec state. Otherwise scan all walks
// target codes 0..63 through the one probe unit, one code a cycle, up to
// the first hit. The next item is accepted once the result is latched and
// the output register is free or being taken. Config writes are accepted
// every cycle and must only occur while the block is idle.
module keyboard_matrix_scan_emulator (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  kmse_pkg::t_in_item    i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output kmse_pkg::t_out_item   o_out_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [2:0]            i_cfg_index,
    input  logic [15:0]           i_cfg_data
);

    kmse_pkg::t_cmd     cmd;
    kmse_pkg::t_in_item cur_item;
    logic               probe_hit;

    assign o_cfg_ready = 1'b1;

    kmse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_item      (cur_item),
        .i_probe_hit (probe_hit),
        .o_cmd       (cmd)
    );

    kmse_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (i_in_item),
        .i_cmd       (cmd),
        .o_probe_hit (probe_hit),
        .o_item      (cur_item),
        .o_result    (o_out_item)
    );

endmodule

FILE: test/keyboard_matrix_scan_emulator_test.sv
`timescale 1ns / 1ps

// Key matrix model: tracks host/target key bits and scan counters, predicts the result items
class kmse_scoreboard;
    bit        csr_raw;
    bit        lock_fix;
    bit        caps_fix;
    bit [7:0]  shift_hold;
    bit [3:0]  caps_rep;
    bit        host_dn [72];
    bit        tgt_dn [64];
    bit        tgt_inv [64];
    bit [7:0]  stop_shift;
    bit [7:0]  make_shift;
    bit [5:0]  frc_code;
    bit [15:0] frc_left;
    bit [15:0] none_left;
    bit        skip_lock;
    bit        last_caps;
    bit [3:0]  caps_left;
    kmse_pkg::t_out_item pending[$];
    int        errors;
    int        n_checked;
    int        n_hits;

    function new();
        csr_raw = 1; lock_fix = 0; caps_fix = 0; shift_hold = 8; caps_rep = 3;
        foreach (host_dn[i]) host_dn[i] = 0;
        foreach (tgt_dn[i]) begin
            tgt_dn[i] = 0;
            tgt_inv[i] = 0;
        end
        stop_shift = 0; make_shift = 0; frc_code = 0; frc_left = 0; none_left = 0;
        skip_lock = 0; last_caps = 0; caps_left = 3;
        errors = 0; n_checked = 0; n_hits = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] v);
        case (idx)
            kmse_pkg::REG_CTRL_SHIFT_RAW: csr_raw = v[0];
            kmse_pkg::REG_LOCK_FIX:       lock_fix = v[0];
            kmse_pkg::REG_CAPS_SEMIFIX:   caps_fix = v[0];
            kmse_pkg::REG_SHIFT_HOLD:     shift_hold = v[7:0];
            kmse_pkg::REG_CAPS_REPEAT:    caps_rep = v[3:0];
            default: ;
        endcase
    endfunction

    // host key tables, bit 7 mapped
    function bit [7:0] lower_code(int k);
        if (k <= 28) return 8'(8'h81 + k);
        if (k >= 38 && k <= 47) return 8'(8'hB0 + (k - 38));
        case (k)
            29: return 8'h9F; 31: return 8'hA1; 32: return 8'hA3; 33: return 8'hA4;
            34: return 8'hA5; 35: return 8'hAC; 36: return 8'hAE; 37: return 8'hAF;
            56: return 8'hA0; 57: return 8'hA2; 58: return 8'hA6; 59: return 8'hA7;
            60: return 8'hA8; 61: return 8'hA9; 62: return 8'h80; 63: return 8'hA7;
            64: return 8'hAB; 65: return 8'hAD; 66: return 8'hAD;
            default: return 8'h00;
        endcase
    endfunction

    function bit [7:0] lower_map(int k);
        // 47,48 -> B9; 49..53 -> BA..BE; 54,55 -> BF
        if (k == 47 || k == 48) return 8'hB9;
        if (k >= 49 && k <= 53) return 8'(8'hBA + (k - 49));
        if (k == 54 || k == 55) return 8'hBF;
        return lower_code(k);
    endfunction

    function bit [7:0] shift_map(int k);
        case (k)
            30: return 8'hA0; 56: return 8'hA9; 57: return 8'h80; 58: return 8'h9E;
            59: return 8'hA6; 60: return 8'hAA; 61: return 8'hA8; 62: return 8'h9E;
            63: return 8'hA2; 64: return 8'hAA; 65: return 8'h9F; 66: return 8'hAB;
            default: return lower_map(k);
        endcase
    endfunction

    function bit probe(bit [5:0] sc);
        if (!lock_fix && caps_fix && sc == kmse_pkg::CAPS_CODE && !skip_lock) begin
            if (tgt_dn[kmse_pkg::CAPS_CODE] != last_caps) begin
                caps_left = 4'(caps_left - 4'd1);
                if (caps_left == 0) begin
                    last_caps = tgt_dn[kmse_pkg::CAPS_CODE];
                    caps_left = caps_rep;
                end
                return 1;
            end
            return 0;
        end
        if (none_left != 0) begin
            none_left--;
            return 0;
        end
        if (frc_left != 0 && frc_code == sc) begin
            frc_left--;
            return 1;
        end
        if (sc == kmse_pkg::SHIFT_CODE && stop_shift != 0) begin
            stop_shift--;
            return 0;
        end
        if (sc == kmse_pkg::SHIFT_CODE && make_shift != 0) begin
            make_shift--;
            return 1;
        end
        if (!tgt_dn[sc]) return 0;
        if (tgt_inv[sc]) begin
            if (tgt_dn[kmse_pkg::SHIFT_CODE]) stop_shift = shift_hold;
            else make_shift = shift_hold;
        end
        return 1;
    endfunction

    function void press(int k);
        bit [7:0] e;
        bit inv;
        if (k >= 72) return;
        host_dn[k] = 1;
        if (host_dn[kmse_pkg::HK_LSHIFT] || host_dn[kmse_pkg::HK_RSHIFT]) begin
            e = shift_map(k);
            if (!e[7]) return;
            if ((host_dn[kmse_pkg::HK_LCTRL] || host_dn[kmse_pkg::HK_RCTRL]) && csr_raw) begin
                e = lower_map(k);
                if (!e[7]) return;
                inv = 0;
            end else begin
                inv = (k == 57 || k == 58 || k == 64);
            end
        end else begin
            e = lower_map(k);
            if (!e[7]) return;
            inv = (k == 62 || k == 63 || k == 66);
        end
        tgt_inv[e[5:0]] = inv;
        tgt_dn[e[5:0]] = 1;
    endfunction

    function void release_key(int k);
        bit [7:0] s;
        bit [7:0] l;
        if (k >= 72) return;
        host_dn[k] = 0;
        s = shift_map(k);
        l = lower_map(k);
        if (s[7]) tgt_dn[s[5:0]] = 0;
        if (l[7]) tgt_dn[l[5:0]] = 0;
    endfunction

    // note an accepted input item and queue its predicted result
    function void note_input(kmse_pkg::t_in_item it);
        kmse_pkg::t_out_item r;
        r = '0;
        case (it.opcode)
            kmse_pkg::OP_KEYDOWN: press(it.host_key);
            kmse_pkg::OP_KEYUP:   release_key(it.host_key);
            kmse_pkg::OP_SCAN_ONE: begin
                if (probe(it.pen_address[9:4])) begin
                    r.pen_strobe = 1;
                    r.pen_strobe_address = it.pen_address;
                end
            end
            kmse_pkg::OP_SCAN_ALL: begin
                if (!it.rom_latched) begin
                    for (int i = 0; i < 64; i++) begin
                        if (probe(6'(i))) begin
                            r.pen_strobe = 1;
                            r.pen_strobe_address = 14'(i << 4);
                            break;
                        end
                    end
                end
            end
            kmse_pkg::OP_FORCE: begin
                frc_code = it.target_scan;
                frc_left = it.repeat_count;
            end
            kmse_pkg::OP_FORCE_NON: none_left = it.repeat_count;
            kmse_pkg::OP_SET: begin
                tgt_dn[it.target_scan] = 1;
                tgt_inv[it.target_scan] = 0;
                if (it.target_scan == kmse_pkg::CAPS_CODE) skip_lock = 1;
            end
            default: begin
                tgt_dn[it.target_scan] = 0;
                if (it.target_scan == kmse_pkg::CAPS_CODE) skip_lock = 0;
            end
        endcase
        r.escape_down = tgt_dn[kmse_pkg::ESC_CODE];
        r.m_down = tgt_dn[kmse_pkg::M_CODE];
        pending.push_back(r);
    endfunction

    function void check_result(kmse_pkg::t_out_item got);
        kmse_pkg::t_out_item exp_r;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result item %h", $time, got);
            errors++;
            return;
        end
        exp_r = pending.pop_front();
        n_checked++;
        if (got.pen_strobe) n_hits++;
        if (got.pen_strobe !== exp_r.pen_strobe) begin
            $display("%0t: pen_strobe expected %0d actual %0d", $time,
                     exp_r.pen_strobe, got.pen_strobe);
            errors++;
        end
        if (got.pen_strobe_address !== exp_r.pen_strobe_address) begin
            $display("%0t: pen_strobe_address expected %h actual %h", $time,
                     exp_r.pen_strobe_address, got.pen_strobe_address);
            errors++;
        end
        if (got.escape_down !== exp_r.escape_down) begin
            $display("%0t: escape_down expected %0d actual %0d", $time,
                     exp_r.escape_down, got.escape_down);
            errors++;
        end
        if (got.m_down !== exp_r.m_down) begin
            $display("%0t: m_down expected %0d actual %0d", $time,
                     exp_r.m_down, got.m_down);
            errors++;
        end
    endfunction
endclass

module keyboard_matrix_scan_emulator_test;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    kmse_pkg::t_in_item  in_item;
    logic       out_valid;
    logic       out_ready;
    kmse_pkg::t_out_item out_item;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [2:0] cfg_index;
    logic [15:0] cfg_data;

    kmse_scoreboard keymap;
    bit         stall_on;
    int         n_items;

    keyboard_matrix_scan_emulator dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_item(in_item),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_item(out_item),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    initial clk = 0;
    always #5 clk = ~clk;

    // mostly short gaps, now and then a long one
    function int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // result side: random stalls, results checked at the rising edge
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) keymap.check_result(out_item);
    end

    initial begin
        int g;
        out_ready = 0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (!stall_on) out_ready = 1;
            else begin
                g = gap_len();
                out_ready = (g == 0);
                repeat (g) @(negedge clk);
                out_ready = 1;
            end
        end
    end

    task automatic send_item(kmse_pkg::t_in_item it);
        int g;
        g = stall_on ? gap_len() : 0;
        repeat (g) @(negedge clk);
        in_item = it;
        in_valid = 1;
        do @(posedge clk); while (!in_ready);
        keymap.note_input(it);
        n_items++;
        @(negedge clk);
        in_valid = 0;
        in_item = '0;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] v);
        cfg_index = idx;
        cfg_data = v;
        cfg_valid = 1;
        do @(posedge clk); while (!cfg_ready);
        keymap.write_reg(idx, v);
        @(negedge clk);
        cfg_valid = 0;
    endtask

    // let every expected result drain, plus the longest scan time
    task automatic drain();
        while (keymap.pending.size() != 0) @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    function automatic kmse_pkg::t_in_item mk(logic [2:0] op, int hk, int addr, int ts,
                                              int cnt, bit lat);
        kmse_pkg::t_in_item it;
        it.opcode = op;
        it.host_key = 7'(hk);
        it.pen_address = 14'(addr);
        it.target_scan = 6'(ts);
        it.repeat_count = 16'(cnt);
        it.rom_latched = lat;
        return it;
    endfunction

    // random item, weighted toward key traffic and scans, with mostly small repeat counts
    function automatic kmse_pkg::t_in_item rand_item();
        kmse_pkg::t_in_item it;
        logic [63:0] w;
        int r;
        w = {$urandom(), $urandom()};
        it = w[$bits(kmse_pkg::t_in_item)-1:0];
        r = $urandom_range(0, 99);
        if (r < 28) it.opcode = kmse_pkg::OP_KEYDOWN;
        else if (r < 48) it.opcode = kmse_pkg::OP_KEYUP;
        else if (r < 63) it.opcode = kmse_pkg::OP_SCAN_ONE;
        else if (r < 78) it.opcode = kmse_pkg::OP_SCAN_ALL;
        else if (r < 84) it.opcode = kmse_pkg::OP_FORCE;
        else if (r < 88) it.opcode = kmse_pkg::OP_FORCE_NON;
        else if (r < 95) it.opcode = kmse_pkg::OP_SET;
        else it.opcode = kmse_pkg::OP_CLEAR;
        if ($urandom_range(0, 9) < 9) it.host_key = 7'($urandom_range(0, 71));
        if ($urandom_range(0, 3) == 0)
            it.host_key = ($urandom_range(0, 1)) ? kmse_pkg::HK_LSHIFT : kmse_pkg::HK_LCTRL;
        if ($urandom_range(0, 3) != 0) it.repeat_count = 16'($urandom_range(0, 20));
        if ($urandom_range(0, 3) != 0) it.rom_latched = 0;
        if ($urandom_range(0, 4) == 0) it.target_scan = kmse_pkg::CAPS_CODE;
        return it;
    endfunction

    initial begin
        rst_n = 0;
        in_valid = 0;
        in_item = '0;
        cfg_valid = 0;
        cfg_index = kmse_pkg::REG_CTRL_SHIFT_RAW;
        cfg_data = '0;
        stall_on = 0;
        n_items = 0;
        keymap = new();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: field extremes, every op, shift and ctrl cases
        send_item(mk(kmse_pkg::OP_KEYDOWN, 0, 0, 0, 0, 0));
        send_item(mk(kmse_pkg::OP_KEYDOWN, 127, 16383, 63, 65535, 1));
        send_item(mk(kmse_pkg::OP_KEYDOWN, 30, 0, 0, 0, 0));
        send_item(mk(kmse_pkg::OP_KEYDOWN, 62, 0, 0, 0, 0));
        send_item(mk(kmse_pkg::OP_SCAN_ALL, 0, 0, 0, 0, 0));
        send_item(mk(kmse_pkg::OP_SCAN_ONE, 0, 16383, 0, 0, 0));
        send_item(mk(kmse_pkg::OP_KEYDOWN, 54, 0, 0, 0, 0));
        send_item(mk(kmse_pkg::OP_KEYDOWN, 57, 0, 0, 0, 0));
        send_item(mk(kmse_pkg::OP_KEYDOWN, 47, 0, 0, 0, 0));
        send_item(mk(kmse_pkg::OP_KEYDOWN, 30, 0, 0, 0, 0));
        send_item(mk(kmse_pkg::OP_KEYDOWN, 58, 0, 0, 0, 0));
        send_item(mk(kmse_pkg::OP_SCAN_ONE, 0, 14'h3F0, 0, 0, 0));
        send_item(mk(kmse_pkg::OP_KEYUP, 71, 0, 0, 0, 0));
        send_item(mk(kmse_pkg::OP_KEYUP, 127, 0, 0, 0, 0));
        send_item(mk(kmse_pkg::OP_KEYUP, 0, 0, 0, 0, 0));
        send_item(mk(kmse_pkg::OP_FORCE, 0, 0, 63, 3, 0));
        send_item(mk(kmse_pkg::OP_SCAN_ALL, 0, 0, 0, 0, 1));
        send_item(mk(kmse_pkg::OP_SCAN_ALL, 0, 0, 0, 0, 0));
        send_item(mk(kmse_pkg::OP_FORCE_NON, 0, 0, 0, 65535, 0));
        send_item(mk(kmse_pkg::OP_SCAN_ONE, 0, 14'h1230, 0, 0, 0));
        send_item(mk(kmse_pkg::OP_FORCE_NON, 0, 0, 0, 0, 0));
        send_item(mk(kmse_pkg::OP_SET, 0, 0, 48, 0, 0));
        send_item(mk(kmse_pkg::OP_SET, 0, 0, 13, 0, 0));
        send_item(mk(kmse_pkg::OP_CLEAR, 0, 0, 48, 0, 0));
        send_item(mk(kmse_pkg::OP_SET, 0, 0, 53, 0, 0));
        drain();

        stall_on = 1;
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    write_reg(kmse_pkg::REG_CAPS_SEMIFIX, 1);
                    write_reg(kmse_pkg::REG_LOCK_FIX, 0);
                    write_reg(kmse_pkg::REG_CAPS_REPEAT, 1);
                end
                1: begin
                    write_reg(kmse_pkg::REG_CTRL_SHIFT_RAW, 0);
                    write_reg(kmse_pkg::REG_SHIFT_HOLD, 255);
                    write_reg(kmse_pkg::REG_CAPS_REPEAT, 15);
                end
                2: begin
                    write_reg(kmse_pkg::REG_LOCK_FIX, 1);
                    write_reg(kmse_pkg::REG_SHIFT_HOLD, 0);
                    write_reg(kmse_pkg::REG_CAPS_REPEAT, 0);
                end
                3: begin
                    write_reg(kmse_pkg::REG_CTRL_SHIFT_RAW, 1);
                    write_reg(kmse_pkg::REG_LOCK_FIX, 0);
                    write_reg(kmse_pkg::REG_SHIFT_HOLD, 16'($urandom_range(1, 20)));
                    write_reg(kmse_pkg::REG_CAPS_REPEAT, 16'($urandom_range(1, 15)));
                end
                default: begin
                    write_reg(kmse_pkg::REG_CAPS_SEMIFIX, 0);
                    write_reg(kmse_pkg::REG_SHIFT_HOLD, 8);
                    write_reg(kmse_pkg::REG_CAPS_REPEAT, 3);
                end
            endcase
            for (int n = 0; n < 90; n++) begin
                // sender waits for the block to empty once per phase
                if (n == 45) while (keymap.pending.size() != 0) @(negedge clk);
                if (ph == 4 && n < 30) stall_on = 0;
                else stall_on = 1;
                send_item(rand_item());
            end
            drain();
        end

        $display("Checked %0d results from %0d items, %0d with a strobe,",
                 keymap.n_checked, n_items, keymap.n_hits);
        $display("over five register settings with random stalls on both sides.");
        if (keymap.errors == 0 && keymap.pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end
endmodule
